/* hw/rtl/cmf_pkg.sv */
// ----------------------------------------------------------------------------
// cmf_pkg
// Shared sample width and the result/queue types of the cross mean filter.
// ----------------------------------------------------------------------------
package cmf_pkg;

  localparam int SAMPLE_W = 8;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                run_last;
    logic                image_last;
  } result_t;

  // up to two results written per accepted input word; valid1 implies valid0
  typedef struct packed {
    logic    valid0;
    logic    valid1;
    result_t r0;
    result_t r1;
  } push_t;

  typedef struct packed {
    logic ready;   // room for two more results
  } q_status_t;

endpackage

/* hw/rtl/cross_mean_filter.sv */
// ----------------------------------------------------------------------------
// cross_mean_filter
// Streaming mean filter over 8-bit samples in raster order.
// Slave side (s_*) takes one sample per word; master side (m_*) gives the
// filtered sample with tlast on the last result caused by an input word and
// tuser on the final sample of the image or sequence. Line mode gives the
// three-tap mean, image mode the five-point cross mean; borders are copied.
// Registers are written through cfg_we/cfg_index/cfg_data while idle, a rule
// on the user, not enforced by the block; each write restarts the frame.
// Throughput: one word per cycle on both sides. Inputs of the last image row
// and the last sample of a line each cause two results, so the input stalls
// to the output rate there. Results lag the input by one row in image mode
// and one sample in line mode; a result is written into the result queue
// before it reaches m_*. A four-entry result queue parts the two sides: the
// input keeps flowing while m_tready is low until fewer than two results of
// room are left.
// Reset clears counters and the queue and loads image mode at 1024 x 1024;
// the line store is not cleared.
// ----------------------------------------------------------------------------
module cross_mean_filter #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,     // [7:0] sample_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,     // [7:0] filtered_sample
  output logic        m_tlast,     // run_last
  output logic        m_tuser,     // [0] image_last
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import cmf_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int AW    = CW + 1;
  localparam int DEPTH = 2 ** AW;

  localparam logic [1:0] REG_FILTER_MODE  = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = 20'(x) * 20'd683;
    return p[18:11];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd3277;
    return p[21:14];
  endfunction

  logic          filter_mode;
  logic [10:0]   image_width;
  logic [12:0]   image_height;
  logic [CW-1:0] col, col_next, pcol, w_m1;
  logic [RW-1:0] row, row_next, prow, h_m1;
  logic          acc, last_col, last_row, h_one, interior;

  logic [AW-1:0] addr_a, addr_b, waddr;
  logic          we, a_hit, b_hit, byp_a, byp_b;
  logic [7:0]    byp_data, ram_a, ram_b, rd_a, rd_b;
  logic [7:0]    cell1_q, cell2_q, centre;
  logic [10:0]   sum5;
  logic [9:0]    sum3;
  logic [7:0]    mean5, mean3;

  push_t     push, q_push;
  q_status_t q_stat;
  result_t   head;

  assign acc      = s_tvalid && s_tready;
  assign s_tready = q_stat.ready;

  // effective size minus one, zero treated as one, saturated to the maximum
  always_comb begin
    if (image_width == '0) begin
      w_m1 = '0;
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_m1 = CW'(MAX_WIDTH - 1);
    end else begin
      w_m1 = CW'(image_width - 11'd1);
    end
    if (image_height == '0) begin
      h_m1 = '0;
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      h_m1 = RW'(MAX_HEIGHT - 1);
    end else begin
      h_m1 = RW'(image_height - 13'd1);
    end
  end

  assign last_col = (col == w_m1);
  assign last_row = (row == h_m1);
  assign h_one    = (h_m1 == '0);

  always_comb begin
    if (last_col) begin
      col_next = '0;
      row_next = (filter_mode && !last_row) ? row + 1'b1 : '0;
    end else begin
      col_next = col + 1'b1;
      row_next = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode  <= 1'b1;
      image_width  <= 11'd1024;
      image_height <= 13'd1024;
      col          <= '0;
      row          <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FILTER_MODE: begin
          filter_mode <= cfg_data[0];
          col         <= '0;
          row         <= '0;
        end
        REG_IMAGE_WIDTH: begin
          image_width <= cfg_data[10:0];
          col         <= '0;
          row         <= '0;
        end
        REG_IMAGE_HEIGHT: begin
          image_height <= cfg_data;
          col          <= '0;
          row          <= '0;
        end
        default: ;
      endcase
    end else if (acc) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // Reads are issued for the position of the next word, so the registered
  // data is ready when it arrives. Port A: row above, one column ahead.
  // Port B: row above at column 0, else two rows up (same bank as this row).
  assign pcol   = acc ? col_next : col;
  assign prow   = acc ? row_next : row;
  assign addr_a = {~prow[0], CW'(pcol + 1'b1)};
  assign addr_b = (pcol == '0) ? {~prow[0], {CW{1'b0}}} : {prow[0], pcol};
  assign waddr  = {row[0], col};
  assign we     = acc && filter_mode;
  assign a_hit  = we && (waddr == addr_a);
  assign b_hit  = we && (waddr == addr_b);

  // one- and two-sample-wide images read back the word written in the
  // same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_a <= 1'b0;
      byp_b <= 1'b0;
    end else begin
      byp_a <= a_hit;
      byp_b <= b_hit;
    end
    byp_data <= s_tdata;
  end

  assign rd_a = byp_a ? byp_data : ram_a;
  assign rd_b = byp_b ? byp_data : ram_b;

  cmf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (s_tdata),
    .raddr_a (addr_a),
    .rdata_a (ram_a),
    .raddr_b (addr_b),
    .rdata_b (ram_b)
  );

  // window chain: line mode shifts raw samples, image mode shifts the row
  // above, cell 2 picking up column 0 at the start of each row
  cmf_cell u_cell1 (
    .clk      (clk),
    .en       (acc),
    .sel_load (filter_mode),
    .d_chain  (s_tdata),
    .d_load   (rd_a),
    .q        (cell1_q)
  );

  cmf_cell u_cell2 (
    .clk      (clk),
    .en       (acc),
    .sel_load (filter_mode && (col == '0)),
    .d_chain  (cell1_q),
    .d_load   (rd_b),
    .q        (cell2_q)
  );

  assign centre   = (col == '0) ? rd_b : cell1_q;
  assign interior = (col != '0) && !last_col && (row != RW'(1));
  assign sum5     = 11'(centre) + 11'(s_tdata) + 11'(rd_b) + 11'(cell2_q) + 11'(rd_a);
  assign sum3     = 10'(cell2_q) + 10'(cell1_q) + 10'(s_tdata);
  assign mean5    = div5(sum5);
  assign mean3    = div3(sum3);

  always_comb begin
    push = '0;
    if (!filter_mode) begin
      if (col == '0) begin
        if (last_col) begin
          push.valid0 = 1'b1;
          push.r0     = '{sample: s_tdata, run_last: 1'b1, image_last: 1'b1};
        end
      end else begin
        push.valid0 = 1'b1;
        push.r0     = '{sample: (col == CW'(1)) ? cell1_q : mean3,
                        run_last: !last_col, image_last: 1'b0};
        if (last_col) begin
          push.valid1 = 1'b1;
          push.r1     = '{sample: s_tdata, run_last: 1'b1, image_last: 1'b1};
        end
      end
    end else if (h_one) begin
      push.valid0 = 1'b1;
      push.r0     = '{sample: s_tdata, run_last: 1'b1, image_last: last_col};
    end else if (row != '0) begin
      push.valid0 = 1'b1;
      push.r0     = '{sample: interior ? mean5 : centre,
                      run_last: !last_row, image_last: 1'b0};
      if (last_row) begin
        push.valid1 = 1'b1;
        push.r1     = '{sample: s_tdata, run_last: 1'b1, image_last: last_col};
      end
    end
  end

  always_comb begin
    q_push        = push;
    q_push.valid0 = push.valid0 && acc;
    q_push.valid1 = push.valid1 && acc;
  end

  cmf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .status   (q_stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .head     (head)
  );

  assign m_tdata = head.sample;
  assign m_tlast = head.run_last;
  assign m_tuser = head.image_last;

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col <= w_m1)
    else $error("column counter beyond row width");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    row <= h_m1)
    else $error("row counter beyond image height");

  a_bypass: assert property (@(posedge clk) disable iff (rst)
    b_hit |=> (rd_b == $past(s_tdata)))
    else $error("line store bypass returned stale data");

endmodule

/* hw/rtl/cmf_ram.sv */
// ----------------------------------------------------------------------------
// cmf_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module cmf_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 2048,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* hw/rtl/cmf_cell.sv */
// ----------------------------------------------------------------------------
// cmf_cell
// One sample cell of the window chain: takes its neighbor's sample or a
// side-loaded sample on each accepted word.
// ----------------------------------------------------------------------------
module cmf_cell (
  input  logic                         clk,
  input  logic                         en,
  input  logic                         sel_load,
  input  logic [cmf_pkg::SAMPLE_W-1:0] d_chain,
  input  logic [cmf_pkg::SAMPLE_W-1:0] d_load,
  output logic [cmf_pkg::SAMPLE_W-1:0] q
);
  import cmf_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      q <= sel_load ? d_load : d_chain;
    end
  end

endmodule

/* hw/rtl/cmf_queue.sv */
// ----------------------------------------------------------------------------
// cmf_queue
// Four-entry result queue feeding the master side; takes up to two results
// per cycle and hands out one per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module cmf_queue (
  input  logic               clk,
  input  logic               rst,
  input  cmf_pkg::push_t     push,
  output cmf_pkg::q_status_t status,
  output logic               m_tvalid,
  input  logic               m_tready,
  output cmf_pkg::result_t   head
);
  import cmf_pkg::*;

  localparam int QD = 4;
  localparam int PW = $clog2(QD);

  result_t       mem [QD];
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] wr_ptr1;
  logic [PW:0]   count;
  logic [1:0]    push_cnt;
  logic          pop;

  assign pop      = m_tvalid && m_tready;
  assign push_cnt = {1'b0, push.valid0} + {1'b0, push.valid1};
  assign wr_ptr1  = wr_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      rd_ptr <= '0;
      wr_ptr <= '0;
    end else begin
      count  <= count + (PW+1)'(push_cnt) - (PW+1)'(pop);
      rd_ptr <= rd_ptr + PW'(pop);
      wr_ptr <= wr_ptr + PW'(push_cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.valid1) begin
      mem[wr_ptr1] <= push.r1;
    end
  end

  assign head         = mem[rd_ptr];
  assign m_tvalid     = (count != '0);
  assign status.ready = (count <= (PW+1)'(QD - 2));

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (PW+1)'(QD))
    else $error("result queue count out of range");

  a_push_order: assert property (@(posedge clk) disable iff (rst)
    push.valid1 |-> push.valid0)
    else $error("second result pushed without first");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.valid0 && push.valid1) |-> (count <= (PW+1)'(QD - 2)))
    else $error("double push into full queue");

endmodule
